### rtl/masked_gaussian_7tap_line_filter_assert.svh
// Assertion macros shared by the masked Gaussian line filter checkers.
// No dependencies; include by bare file name inside a module body.
`ifndef MASKED_GAUSSIAN_7TAP_LINE_FILTER_ASSERT_SVH
`define MASKED_GAUSSIAN_7TAP_LINE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MGF_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MGF_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mgf_pkg.sv
// Package for the masked Gaussian 7-tap line filter: sizes, register
// indexes and Q12 reset weights. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mgf_pkg;

  localparam int SAMPLE_WIDTH_DEF     = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 12;

  localparam int TAPS  = 7;
  localparam int TAP_W = 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OUTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_INNER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTRE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT    = 3'd4;

  // Reset weights in Q12, rescaled to the actual fraction width at elaboration
  localparam int Q12_ONE          = 4096;
  localparam int RST_Q12_OUTER    = 25;
  localparam int RST_Q12_SECOND   = 250;
  localparam int RST_Q12_INNER    = 991;
  localparam int RST_Q12_CENTRE   = 1565;
  localparam int RST_Q12_MIN_WGT  = 4;

endpackage

`default_nettype wire

### rtl/mgf_if.sv
// Stream interfaces for the masked Gaussian line filter: sample requests in,
// filtered requests out. Valid/ready handshake. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mgf_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           sample_valid;
  logic                           line_end;

  modport source (output valid, sample, sample_valid, line_end, input ready);
  modport sink   (input valid, sample, sample_valid, line_end, output ready);
endinterface

interface mgf_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] value;
  logic                           value_valid;
  logic                           end_of_line;
  logic                           last_of_run;

  modport source (output valid, value, value_valid, end_of_line, last_of_run,
                  input ready);
  modport sink   (input valid, value, value_valid, end_of_line, last_of_run,
                  output ready);
endinterface

`default_nettype wire

### rtl/masked_gaussian_7tap_line_filter.sv
// Masked 7-tap Gaussian line filter, top level and only datapath module.
// Depends on mgf_pkg and the stream interfaces in mgf_if.sv.
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+---------------------------------------------
//   in_ch   | in  | valid / ready  | sample, sample_valid, line_end
//   out_ch  | out | valid / ready  | value, value_valid, end_of_line, last_of_run
//   cfg_*   | in  | cfg_we only    | cfg_index, cfg_wdata
//
// A request is taken while idle, then each of its one to four steps passes
// through planning; every result runs the seven taps through the single
// multiply-accumulate unit, then check, divider load, the shared restoring
// subtractor and finishing, or check and finishing alone when the result is
// flagged invalid and skips the divider; the result is then held on out_ch
// until out_ch.ready. in_ch.ready is high only when idle.
// Reset (rst_n low, synchronous) empties the window, clears the line fill and
// the output valid, and loads the default weights.
`timescale 1ns / 1ps
`default_nettype none

module masked_gaussian_7tap_line_filter
  import mgf_pkg::*;
#(
  parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mgf_in_if.sink                             in_ch,
  mgf_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [WEIGHT_FRAC_BITS+1:0]   cfg_wdata
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int WF     = WEIGHT_FRAC_BITS;
  localparam int MW     = WF + 2;            // min_weight width
  localparam int DEN_W  = WF + 3;            // sum of up to seven weights
  localparam int PROD_W = SW + WF + 1;       // signed sample times unsigned weight
  localparam int ACC_W  = SW + WF + 3;       // signed sum of seven products
  localparam int MAG_W  = ACC_W - 1;
  localparam int N_W    = SW + WF + 4;       // rounding dividend 2*|num| + den
  localparam int REM_W  = WF + 4;            // divisor 2*den and partial remainder
  localparam int CNT_W  = $clog2(SW);

  localparam logic [WF-1:0] RST_OUTER  = WF'((RST_Q12_OUTER  * (1 << WF)) / Q12_ONE);
  localparam logic [WF-1:0] RST_SECOND = WF'((RST_Q12_SECOND * (1 << WF)) / Q12_ONE);
  localparam logic [WF-1:0] RST_INNER  = WF'((RST_Q12_INNER  * (1 << WF)) / Q12_ONE);
  localparam logic [WF-1:0] RST_CENTRE = WF'((RST_Q12_CENTRE * (1 << WF)) / Q12_ONE);
  localparam logic [MW-1:0] RST_MINW   = MW'((RST_Q12_MIN_WGT * (1 << WF)) / Q12_ONE);

  localparam logic signed [SW-1:0] VALUE_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE, S_PLAN, S_MAC, S_CHK, S_LOAD, S_DIV, S_FIN, S_OUT
  } state_t;

  // Configuration
  logic [WF-1:0] w_outer_r, w_second_r, w_inner_r, w_centre_r;
  logic [MW-1:0] min_weight_r;

  // Window: entry TAPS-1 is the newest
  logic signed [SW-1:0] win_s_r [TAPS];
  logic [TAPS-1:0]      win_v_r;
  logic [1:0]           line_fill_r;

  // Sequencer
  state_t           state_r;
  logic [1:0]       step_r;       // 0: regular result, 1..3: flush shifts
  logic [1:0]       kmin_r;       // first flush step that yields a result
  logic             regular_r;
  logic             line_end_r;
  logic             eol_r;
  logic             last_r;
  logic [TAP_W-1:0] tap_r;
  logic [CNT_W-1:0] cnt_r;

  // Arithmetic
  logic signed [ACC_W-1:0] acc_r;
  logic [DEN_W-1:0]        den_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic                    ok_r;
  logic [REM_W-1:0]        rem_r;
  logic [REM_W-1:0]        dvs_r;
  logic [SW-1:0]           quo_r;

  // Output register
  logic                 out_valid_r;
  logic signed [SW-1:0] out_value_r;
  logic                 out_value_valid_r;
  logic                 out_eol_r;
  logic                 out_last_r;

  logic                    in_fire;
  logic                    out_fire;
  logic [WF-1:0]           tap_w;
  logic signed [PROD_W-1:0] prod;
  logic                    ok_now;
  logic [MAG_W-1:0]        mag_now;
  logic [N_W-1:0]          n_val;
  logic [REM_W:0]          trial;
  logic [REM_W+1:0]        diff;
  logic                    fits;
  logic signed [SW-1:0]    fin_value;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.value_valid = out_value_valid_r;
  assign out_ch.end_of_line = out_eol_r;
  assign out_ch.last_of_run = out_last_r;

  // Symmetric tap weight for the tap under the MAC
  always_comb begin
    unique case (tap_r)
      3'd0, 3'd6: tap_w = w_outer_r;
      3'd1, 3'd5: tap_w = w_second_r;
      3'd2, 3'd4: tap_w = w_inner_r;
      3'd3:       tap_w = w_centre_r;
      default:    tap_w = '0;
    endcase
  end

  assign prod = win_s_r[tap_r] * $signed({1'b0, tap_w});

  // Used weights must be nonzero and reach min_weight
  assign ok_now  = (den_r != '0) && (den_r >= DEN_W'(min_weight_r));
  assign mag_now = acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);

  // Round to nearest: (2*mag + den) / (2*den); quotient fits SW bits
  assign n_val = N_W'({mag_r, 1'b0}) + N_W'(den_r);

  // One restoring divide step
  assign trial = {rem_r, quo_r[SW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign fits  = !diff[REM_W+1];

  always_comb begin
    if (!ok_r) begin
      fin_value = '0;
    end else if (neg_r) begin
      fin_value = -$signed(quo_r);
    end else if (quo_r[SW-1]) begin
      fin_value = VALUE_MAX;
    end else begin
      fin_value = $signed(quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_v_r      <= '0;
      line_fill_r  <= '0;
      out_valid_r  <= 1'b0;
      w_outer_r    <= RST_OUTER;
      w_second_r   <= RST_SECOND;
      w_inner_r    <= RST_INNER;
      w_centre_r   <= RST_CENTRE;
      min_weight_r <= RST_MINW;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WEIGHT_OUTER:  w_outer_r    <= cfg_wdata[WF-1:0];
          REG_WEIGHT_SECOND: w_second_r   <= cfg_wdata[WF-1:0];
          REG_WEIGHT_INNER:  w_inner_r    <= cfg_wdata[WF-1:0];
          REG_WEIGHT_CENTRE: w_centre_r   <= cfg_wdata[WF-1:0];
          REG_MIN_WEIGHT:    min_weight_r <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            // Advance the window with the new sample
            for (int i = 0; i < TAPS - 1; i++) begin
              win_s_r[i] <= win_s_r[i+1];
            end
            win_v_r     <= {in_ch.sample_valid, win_v_r[TAPS-1:1]};
            win_s_r[TAPS-1] <= in_ch.sample;
            regular_r   <= (line_fill_r == 2'd3);
            kmin_r      <= 2'd3 - line_fill_r;
            line_end_r  <= in_ch.line_end;
            step_r      <= 2'd0;
            if (line_fill_r != 2'd3) begin
              line_fill_r <= line_fill_r + 2'd1;
            end
            state_r <= S_PLAN;
          end
        end

        S_PLAN: begin
          tap_r <= '0;
          acc_r <= '0;
          den_r <= '0;
          if (step_r == 2'd0) begin
            if (regular_r) begin
              eol_r   <= 1'b0;
              last_r  <= !line_end_r;
              state_r <= S_MAC;
            end else if (line_end_r) begin
              step_r  <= 2'd1;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            // Flush step: advance the window with an empty entry
            for (int i = 0; i < TAPS - 1; i++) begin
              win_s_r[i] <= win_s_r[i+1];
            end
            win_s_r[TAPS-1] <= '0;
            win_v_r <= {1'b0, win_v_r[TAPS-1:1]};
            if (step_r >= kmin_r) begin
              eol_r   <= (step_r == 2'd3);
              last_r  <= (step_r == 2'd3);
              state_r <= S_MAC;
            end else begin
              step_r  <= step_r + 2'd1;
            end
          end
        end

        S_MAC: begin
          if (win_v_r[tap_r]) begin
            acc_r <= acc_r + ACC_W'(prod);
            den_r <= den_r + DEN_W'(tap_w);
          end
          tap_r <= tap_r + 1'b1;
          if (tap_r == TAP_W'(TAPS - 1)) begin
            state_r <= S_CHK;
          end
        end

        S_CHK: begin
          ok_r  <= ok_now;
          neg_r <= acc_r[ACC_W-1];
          mag_r <= mag_now;
          state_r <= ok_now ? S_LOAD : S_FIN;
        end

        S_LOAD: begin
          rem_r   <= n_val[N_W-1:SW];
          quo_r   <= n_val[SW-1:0];
          dvs_r   <= {den_r, 1'b0};
          cnt_r   <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          rem_r <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
          quo_r <= {quo_r[SW-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SW - 1)) begin
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          out_valid_r       <= 1'b1;
          out_value_r       <= fin_value;
          out_value_valid_r <= ok_r;
          out_eol_r         <= eol_r;
          out_last_r        <= last_r;
          state_r           <= S_OUT;
        end

        S_OUT: begin
          // Hold the result until the sink takes it
          if (out_fire) begin
            out_valid_r <= 1'b0;
            if (step_r == 2'd0) begin
              if (line_end_r) begin
                step_r  <= 2'd1;
                state_r <= S_PLAN;
              end else begin
                state_r <= S_IDLE;
              end
            end else if (step_r == 2'd3) begin
              // Line done: drop the whole window
              win_v_r     <= '0;
              line_fill_r <= '0;
              state_r     <= S_IDLE;
            end else begin
              step_r  <= step_r + 2'd1;
              state_r <= S_PLAN;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/mgf_checker.sv
// Port-level checker for the masked Gaussian line filter, bound to the top.
// Depends on mgf_pkg and masked_gaussian_7tap_line_filter_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module mgf_checker
  import mgf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] out_value,
  input wire logic                    out_value_valid,
  input wire logic                    out_end_of_line,
  input wire logic                    out_last_of_run
);

`include "masked_gaussian_7tap_line_filter_assert.svh"

  `MGF_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready, "ready while result pending")
  `MGF_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "ready after request")
  `MGF_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && !out_value_valid, out_value == '0, "invalid value nonzero")
  `MGF_ASSERT_NOW(a_eol_last, clk, rst_n, out_valid && out_end_of_line, out_last_of_run, "end of line not last")
  `MGF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value), "stalled result changed")

endmodule

bind masked_gaussian_7tap_line_filter mgf_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_mgf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_value       (out_ch.value),
  .out_value_valid (out_ch.value_valid),
  .out_end_of_line (out_ch.end_of_line),
  .out_last_of_run (out_ch.last_of_run)
);

`default_nettype wire
